// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro takes a label, the clock, the property and a message; TSP_ASSERT also takes the reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps

package tsp_pkg;

    // Field widths.
    localparam int DistW  = 16;
    localparam int SpeedW = 12;
    localparam int MeasW  = 13;
    localparam int AccelW = 8;
    localparam int DecelW = 12;

    // Configuration register indexes.
    localparam logic [7:0] RegMaxSpeed     = 8'd0;
    localparam logic [7:0] RegAccelStep    = 8'd1;
    localparam logic [7:0] RegDecelRate    = 8'd2;
    localparam logic [7:0] RegBrakeDist    = 8'd3;

    // Register values after reset.
    localparam logic [SpeedW-1:0] MaxSpeedReset  = 12'd600;
    localparam logic [AccelW-1:0] AccelStepReset = 8'd6;
    localparam logic [DecelW-1:0] DecelRateReset = 12'd600;
    localparam logic [DistW-1:0]  BrakeDistReset = 16'd300;

    // Last counter values of the serial phases.
    localparam logic [3:0] MulLast  = 4'd15;
    localparam logic [3:0] SqrtLast = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ARG,
        ST_SQRT,
        ST_DONE
    } tsp_state_t;

endpackage

// ===== hw/rtl/trapezoid_speed_profile.sv =====
`timescale 1ns / 1ps
// Each input transfer runs through the states MUL (bit-serial multiply of the root
// argument terms), ARG, SQRT (bit-serial square root) and DONE, which registers the
// result; no new input is taken until the result is loaded into the output register.
// The next input is taken while the previous result still waits on m_tready.
// Reset (aresetn low, synchronous) clears the commanded speed and the result
// valid flag and restores the configuration registers to 600, 6, 600 and 300.

module trapezoid_speed_profile
    import tsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] target_distance, [28:16] measured_speed
    input  logic        s_tuser,   // [0] reverse
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [12:0] speed_command
    output logic        m_tuser    // [0] braking
);

    tsp_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    logic [SpeedW-1:0] max_speed_reg;
    logic [AccelW-1:0] accel_reg;
    logic [DecelW-1:0] decel_reg;
    logic [DistW-1:0]  brake_dist_reg;
    logic [SpeedW-1:0] cmd_reg, cmd_next;

    // Serial multiplier operands and accumulators.
    logic [SpeedW-1:0]   sq_mplier_reg;
    logic [2*SpeedW-1:0] sq_mcand_reg;
    logic [2*SpeedW-1:0] sq_acc_reg;
    logic [DistW-1:0]    pr_mplier_reg;
    logic [27:0]         pr_mcand_reg;
    logic [27:0]         pr_acc_reg;

    // Square root state.
    logic [2*SpeedW-1:0] arg_sr_reg;
    logic [12:0]         rem_reg;
    logic [SpeedW-1:0]   root_reg;

    // Item fields held for the final step.
    logic [MeasW-1:0] mag_reg;
    logic             rev_reg;
    logic             braking_reg;

    logic             m_tvalid_reg;
    logic [MeasW-1:0] speed_out_reg;
    logic             braking_out_reg;

    logic take_in, mul_step, arg_load, sqrt_step, ld_out, cnt_clear;

    logic [DistW-1:0]  in_dist;
    logic [MeasW-1:0]  in_meas;
    logic [MeasW-1:0]  in_mag;
    logic [29:0]       arg_diff;
    logic [14:0]       rem_wide, trial;
    logic              root_bit;
    logic [12:0]       ramp_sum;
    logic [SpeedW-1:0] ramp_cap;
    logic [MeasW-1:0]  speed_signed;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, speed_out_reg};
    assign m_tuser   = braking_out_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == MulLast) state_next = ST_ARG;
            ST_ARG:  state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == SqrtLast) state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_tready  = 1'b0;
        mul_step  = 1'b0;
        arg_load  = 1'b0;
        sqrt_step = 1'b0;
        ld_out    = 1'b0;
        cnt_clear = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cnt_clear = 1'b1;
            end
            ST_MUL:  mul_step = 1'b1;
            ST_ARG: begin
                arg_load  = 1'b1;
                cnt_clear = 1'b1;
            end
            ST_SQRT: sqrt_step = 1'b1;
            ST_DONE: ld_out = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    assign take_in  = s_tvalid && s_tready;
    assign cnt_next = cnt_clear ? 4'd0 : cnt_reg + 4'd1;

    // Input unpacking; the magnitude of -4096 is 4096 in 13 bits.
    assign in_dist = s_tdata[15:0];
    assign in_meas = s_tdata[28:16];
    assign in_mag  = in_meas[MeasW-1] ? (~in_meas + 13'd1) : in_meas;

    // Root argument: max_speed^2 minus twice decel times (brake distance minus target distance).
    assign arg_diff = {6'd0, sq_acc_reg} - {1'b0, pr_acc_reg, 1'b0};

    // One root bit per cycle from two argument bits.
    assign rem_wide = {rem_reg, arg_sr_reg[2*SpeedW-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign root_bit = rem_wide >= trial;

    // Command update.
    assign ramp_sum = {1'b0, cmd_reg} + {5'd0, accel_reg};
    always_comb begin
        ramp_cap = cmd_reg;
        cmd_next = cmd_reg;
        if (braking_reg) begin
            if ({1'b0, root_reg} > mag_reg) begin
                ramp_cap = (ramp_sum > {1'b0, root_reg}) ? root_reg : ramp_sum[SpeedW-1:0];
                cmd_next = (ramp_cap > max_speed_reg) ? max_speed_reg : ramp_cap;
            end else begin
                cmd_next = root_reg;
            end
        end else if (cmd_reg < max_speed_reg) begin
            cmd_next = (ramp_sum > {1'b0, max_speed_reg}) ? max_speed_reg
                                                          : ramp_sum[SpeedW-1:0];
        end
    end
    assign speed_signed = rev_reg ? (13'd0 - {1'b0, cmd_next}) : {1'b0, cmd_next};

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= 4'd0;
            max_speed_reg  <= MaxSpeedReset;
            accel_reg      <= AccelStepReset;
            decel_reg      <= DecelRateReset;
            brake_dist_reg <= BrakeDistReset;
            cmd_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    RegMaxSpeed:  max_speed_reg  <= cfg_data[SpeedW-1:0];
                    RegAccelStep: accel_reg      <= cfg_data[AccelW-1:0];
                    RegDecelRate: decel_reg      <= cfg_data[DecelW-1:0];
                    RegBrakeDist: brake_dist_reg <= cfg_data[DistW-1:0];
                    default:      ;
                endcase
            end
            if (ld_out) begin
                cmd_reg <= cmd_next;
            end
            if (ld_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Serial datapath and output payload.
    always_ff @(posedge aclk) begin
        if (take_in) begin
            sq_mplier_reg <= max_speed_reg;
            sq_mcand_reg  <= {12'd0, max_speed_reg};
            sq_acc_reg    <= '0;
            pr_mplier_reg <= brake_dist_reg - in_dist;
            pr_mcand_reg  <= {16'd0, decel_reg};
            pr_acc_reg    <= '0;
            mag_reg       <= in_mag;
            rev_reg       <= s_tuser;
            braking_reg   <= in_dist < brake_dist_reg;
        end else if (mul_step) begin
            sq_mplier_reg <= sq_mplier_reg >> 1;
            sq_mcand_reg  <= sq_mcand_reg << 1;
            pr_mplier_reg <= pr_mplier_reg >> 1;
            pr_mcand_reg  <= pr_mcand_reg << 1;
            if (sq_mplier_reg[0]) begin
                sq_acc_reg <= sq_acc_reg + sq_mcand_reg;
            end
            if (pr_mplier_reg[0]) begin
                pr_acc_reg <= pr_acc_reg + pr_mcand_reg;
            end
        end
        // A negative or zero argument gives a root of zero.
        if (arg_load) begin
            arg_sr_reg <= arg_diff[29] ? '0 : arg_diff[2*SpeedW-1:0];
            rem_reg    <= '0;
            root_reg   <= '0;
        end else if (sqrt_step) begin
            arg_sr_reg <= arg_sr_reg << 2;
            rem_reg    <= root_bit ? 13'(rem_wide - trial) : rem_wide[12:0];
            root_reg   <= {root_reg[SpeedW-2:0], root_bit};
        end
        if (ld_out) begin
            speed_out_reg   <= speed_signed;
            braking_out_reg <= braking_reg;
        end
    end

endmodule

// ===== hw/rtl/tsp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A result held back by the sink keeps its value.
    `TSP_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // The block works on one item at a time.
    `TSP_ASSERT(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

    // The command magnitude never exceeds 4095, so -4096 never appears.
    `TSP_ASSERT(a_cmd_range, aclk, aresetn, m_tvalid |-> m_tdata[12:0] != 13'h1000 && m_tdata[15:13] == 3'b000, "command out of range")

    // Reset empties the result stage.
    `TSP_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind trapezoid_speed_profile tsp_checker u_tsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
